[src/ccr_pkg.sv]
// Package for the centre-crop resize to gray block: constants, codes and
// pipeline record types. Depends on nothing.
package ccr_pkg;

    localparam int FRAME_BYTES = 131072;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int WORD_DEPTH  = FRAME_BYTES / 2;
    localparam int WORD_AW     = $clog2(WORD_DEPTH);
    localparam int DIM_W       = 8;
    localparam int DVD_W       = 16;
    localparam int DIV_STAGES  = DVD_W;
    localparam int SUM_W       = 15;
    localparam int PROD_W      = 28;
    localparam int RECIP_SHIFT = 19;

    localparam logic [DIM_W-1:0] CAMERA_WIDTH_RST  = 8'd176;
    localparam logic [DIM_W-1:0] CAMERA_HEIGHT_RST = 8'd144;
    localparam logic [DIM_W-1:0] MODEL_WIDTH_RST   = 8'd96;
    localparam logic [DIM_W-1:0] MODEL_HEIGHT_RST  = 8'd96;

    localparam logic [SUM_W-1:0]  WEIGHT_R  = 15'd30;
    localparam logic [SUM_W-1:0]  WEIGHT_G  = 15'd59;
    localparam logic [SUM_W-1:0]  WEIGHT_B  = 15'd11;
    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
    localparam logic [PROD_W-1:0] RECIP_100 = 28'd5243;

    typedef enum logic [1:0] {
        REG_CAMERA_WIDTH  = 2'd0,
        REG_CAMERA_HEIGHT = 2'd1,
        REG_MODEL_WIDTH   = 2'd2,
        REG_MODEL_HEIGHT  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              last;
    } item_t;

    typedef struct packed {
        item_t item;
        logic  oor;
        logic  wide;
    } line_a_t;

    typedef struct packed {
        item_t            item;
        logic             oor;
        logic [DIM_W-1:0] crop_x;
        logic [DIM_W-1:0] crop_y;
    } line_b_t;

endpackage

[src/ccr_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ccr_pkg for the operand widths.
module ccr_div
    import ccr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIM_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic [DIM_W-1:0] remainder
);

    logic [DVD_W-1:0] dvd_reg [DIV_STAGES];
    logic [DVD_W-1:0] quo_reg [DIV_STAGES];
    logic [DIM_W-1:0] rem_reg [DIV_STAGES];
    logic [DIM_W-1:0] dvs_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic [DVD_W-1:0] dvd_in;
            logic [DVD_W-1:0] quo_in;
            logic [DIM_W-1:0] rem_in;
            logic [DIM_W-1:0] dvs_in;
            logic [DIM_W:0]   trial;
            logic             fits;

            if (k == 0) begin : g_first
                assign dvd_in = dividend;
                assign quo_in = '0;
                assign rem_in = '0;
                assign dvs_in = divisor;
            end
            else begin : g_next
                assign dvd_in = dvd_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign dvs_in = dvs_reg[k-1];
            end

            assign trial = {rem_in, dvd_in[DVD_W-1]};
            assign fits  = trial >= {1'b0, dvs_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dvd_reg[k] <= {dvd_in[DVD_W-2:0], 1'b0};
                    quo_reg[k] <= {quo_in[DVD_W-2:0], fits};
                    rem_reg[k] <= fits ? DIM_W'(trial - {1'b0, dvs_in}) : DIM_W'(trial);
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    endgenerate

    assign quotient  = quo_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1];

endmodule

[src/center_crop_resize_rgb565_gray.sv]
// Centre-crop nearest-neighbour resize of an RGB565 frame store to gray.
// Each request gives one result at the end of the pipeline; writes give none.
// Throughput: one item per cycle; the whole pipeline advances together and
// halts only while a finished result is held on a stalled output.
// Reset clears valids and loads the default sizes; the frame store keeps
// its contents and is undefined until written. Depends on ccr_pkg, ccr_div.
module center_crop_resize_rgb565_gray
    import ccr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [DIM_W-1:0]   cfg_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               operation,
    input  logic [ADDR_W-1:0]  byte_address,
    input  logic [7:0]         byte_value,
    input  logic [DVD_W-1:0]   pixel_index,
    input  logic               last_request,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [23:0]        gray_word,
    output logic               out_of_range,
    output logic               last_result
);

    logic [DIM_W-1:0] cam_w_reg, cam_h_reg, mod_w_reg, mod_h_reg;
    logic [DIM_W-1:0] cw, ch, mw, mh;
    logic             adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_w_reg <= CAMERA_WIDTH_RST;
            cam_h_reg <= CAMERA_HEIGHT_RST;
            mod_w_reg <= MODEL_WIDTH_RST;
            mod_h_reg <= MODEL_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAMERA_WIDTH:  cam_w_reg <= cfg_data;
                REG_CAMERA_HEIGHT: cam_h_reg <= cfg_data;
                REG_MODEL_WIDTH:   mod_w_reg <= cfg_data;
                REG_MODEL_HEIGHT:  mod_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a zero size acts as one
    assign cw = (cam_w_reg == '0) ? DIM_W'(1) : cam_w_reg;
    assign ch = (cam_h_reg == '0) ? DIM_W'(1) : cam_h_reg;
    assign mw = (mod_w_reg == '0) ? DIM_W'(1) : mod_w_reg;
    assign mh = (mod_h_reg == '0) ? DIM_W'(1) : mod_h_reg;

    // ---------------- accept stage
    logic             res_valid_reg;
    logic             p0_vld_reg;
    item_t            p0_item_reg;
    logic [DVD_W-1:0] p0_pix_reg;

    assign adv       = !res_valid_reg || !res_stall;
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_vld_reg <= 1'b0;
        else if (adv)
            p0_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_item_reg <= '{op: op_t'(operation), addr: byte_address,
                             data: byte_value, last: last_request};
            p0_pix_reg  <= pixel_index;
        end
    end

    // ---------------- size products
    logic             p1_vld_reg;
    item_t            p1_item_reg;
    logic [DVD_W-1:0] p1_pix_reg, p1_mwmh_reg, p1_cwmh_reg, p1_chmw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else if (adv)
            p1_vld_reg <= p0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_item_reg <= p0_item_reg;
            p1_pix_reg  <= p0_pix_reg;
            p1_mwmh_reg <= DVD_W'(mw * mh);
            p1_cwmh_reg <= DVD_W'(cw * mh);
            p1_chmw_reg <= DVD_W'(ch * mw);
        end
    end

    // ---------------- first divider bank: pixel row/column and crop size
    logic [DVD_W-1:0] q_pix, q_cropw, q_croph;
    logic [DIM_W-1:0] r_pix, r_cropw_unused, r_croph_unused;
    logic             wide;

    assign wide = p1_cwmh_reg > p1_chmw_reg;

    ccr_div u_div_pix (.clk(clk), .en(adv), .dividend(p1_pix_reg), .divisor(mw),
                       .quotient(q_pix), .remainder(r_pix));
    ccr_div u_div_cw  (.clk(clk), .en(adv), .dividend(p1_chmw_reg), .divisor(mh),
                       .quotient(q_cropw), .remainder(r_cropw_unused));
    ccr_div u_div_ch  (.clk(clk), .en(adv), .dividend(p1_cwmh_reg), .divisor(mw),
                       .quotient(q_croph), .remainder(r_croph_unused));

    logic    line_a_vld_reg [DIV_STAGES];
    line_a_t line_a_reg [DIV_STAGES];
    line_a_t line_a_next;

    always_comb
    begin
        line_a_next.item = p1_item_reg;
        line_a_next.oor  = p1_pix_reg >= p1_mwmh_reg;
        line_a_next.wide = wide;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                line_a_vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            line_a_vld_reg[0] <= p1_vld_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                line_a_vld_reg[i] <= line_a_vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_a_reg[0] <= line_a_next;
            for (int i = 1; i < DIV_STAGES; i++)
                line_a_reg[i] <= line_a_reg[i-1];
        end
    end

    // ---------------- crop window
    line_a_t          a_out;
    logic [DIM_W-1:0] crop_w, crop_h;
    logic             p2_vld_reg;
    item_t            p2_item_reg;
    logic             p2_oor_reg;
    logic [DIM_W-1:0] p2_mx_reg, p2_my_reg, p2_cropw_reg, p2_croph_reg;
    logic [DIM_W-1:0] p2_cropx_reg, p2_cropy_reg;

    assign a_out  = line_a_reg[DIV_STAGES-1];
    assign crop_w = a_out.wide ? DIM_W'(q_cropw) : cw;
    assign crop_h = a_out.wide ? ch : DIM_W'(q_croph);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_vld_reg <= 1'b0;
        else if (adv)
            p2_vld_reg <= line_a_vld_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_item_reg  <= a_out.item;
            p2_oor_reg   <= a_out.oor;
            p2_mx_reg    <= r_pix;
            p2_my_reg    <= DIM_W'(q_pix);
            p2_cropw_reg <= crop_w;
            p2_croph_reg <= crop_h;
            p2_cropx_reg <= a_out.wide ? DIM_W'((cw - crop_w) >> 1) : '0;
            p2_cropy_reg <= a_out.wide ? '0 : DIM_W'((ch - crop_h) >> 1);
        end
    end

    // ---------------- scale products
    logic             p3_vld_reg;
    item_t            p3_item_reg;
    logic             p3_oor_reg;
    logic [DVD_W-1:0] p3_px_reg, p3_py_reg;
    logic [DIM_W-1:0] p3_cropx_reg, p3_cropy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_vld_reg <= 1'b0;
        else if (adv)
            p3_vld_reg <= p2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_item_reg  <= p2_item_reg;
            p3_oor_reg   <= p2_oor_reg;
            p3_px_reg    <= DVD_W'(p2_mx_reg * p2_cropw_reg);
            p3_py_reg    <= DVD_W'(p2_my_reg * p2_croph_reg);
            p3_cropx_reg <= p2_cropx_reg;
            p3_cropy_reg <= p2_cropy_reg;
        end
    end

    // ---------------- second divider bank: offsets inside the crop
    logic [DVD_W-1:0] q_x, q_y;
    logic [DIM_W-1:0] r_x_unused, r_y_unused;

    ccr_div u_div_x (.clk(clk), .en(adv), .dividend(p3_px_reg), .divisor(mw),
                     .quotient(q_x), .remainder(r_x_unused));
    ccr_div u_div_y (.clk(clk), .en(adv), .dividend(p3_py_reg), .divisor(mh),
                     .quotient(q_y), .remainder(r_y_unused));

    logic    line_b_vld_reg [DIV_STAGES];
    line_b_t line_b_reg [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                line_b_vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            line_b_vld_reg[0] <= p3_vld_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                line_b_vld_reg[i] <= line_b_vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            line_b_reg[0].item   <= p3_item_reg;
            line_b_reg[0].oor    <= p3_oor_reg;
            line_b_reg[0].crop_x <= p3_cropx_reg;
            line_b_reg[0].crop_y <= p3_cropy_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                line_b_reg[i] <= line_b_reg[i-1];
        end
    end

    // ---------------- camera coordinates
    line_b_t          b_out;
    logic             p4_vld_reg;
    item_t            p4_item_reg;
    logic             p4_oor_reg;
    logic [DIM_W-1:0] p4_cx_reg, p4_cy_reg;

    assign b_out = line_b_reg[DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_vld_reg <= 1'b0;
        else if (adv)
            p4_vld_reg <= line_b_vld_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_item_reg <= b_out.item;
            p4_oor_reg  <= b_out.oor;
            p4_cx_reg   <= DIM_W'(b_out.crop_x + DIM_W'(q_x));
            p4_cy_reg   <= DIM_W'(b_out.crop_y + DIM_W'(q_y));
        end
    end

    // ---------------- pixel word address
    logic               p5_vld_reg;
    item_t              p5_item_reg;
    logic               p5_oor_reg;
    logic [WORD_AW-1:0] p5_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_vld_reg <= 1'b0;
        else if (adv)
            p5_vld_reg <= p4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_item_reg <= p4_item_reg;
            p5_oor_reg  <= p4_oor_reg;
            p5_word_reg <= WORD_AW'(p4_cy_reg * cw + DVD_W'(p4_cx_reg));
        end
    end

    // ---------------- frame store: big-endian pixel words, byte writes
    logic [15:0]  frame_mem [WORD_DEPTH];
    logic [15:0]  rd_reg;
    logic         p6_vld_reg;
    logic         p6_req_reg;
    logic         p6_oor_reg;
    logic         p6_last_reg;

    // writes travel the pipeline so they stay in order with reads
    always_ff @(posedge clk)
    begin
        if (adv && p5_vld_reg && p5_item_reg.op == OP_WRITE)
        begin
            if (p5_item_reg.addr[0])
                frame_mem[p5_item_reg.addr[ADDR_W-1:1]][7:0]  <= p5_item_reg.data;
            else
                frame_mem[p5_item_reg.addr[ADDR_W-1:1]][15:8] <= p5_item_reg.data;
        end
        if (adv)
            rd_reg <= frame_mem[p5_word_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p6_vld_reg <= 1'b0;
        else if (adv)
            p6_vld_reg <= p5_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_req_reg  <= p5_item_reg.op == OP_REQUEST;
            p6_oor_reg  <= p5_oor_reg;
            p6_last_reg <= p5_item_reg.last;
        end
    end

    // ---------------- weighted sum
    logic [SUM_W-1:0] r8, g8, b8;
    logic             p7_vld_reg, p7_req_reg, p7_oor_reg, p7_last_reg;
    logic [SUM_W-1:0] p7_sum_reg;

    assign r8 = SUM_W'({rd_reg[15:11], 3'b000});
    assign g8 = SUM_W'({rd_reg[10:5], 2'b00});
    assign b8 = SUM_W'({rd_reg[4:0], 3'b000});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p7_vld_reg <= 1'b0;
        else if (adv)
            p7_vld_reg <= p6_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p7_req_reg  <= p6_req_reg;
            p7_oor_reg  <= p6_oor_reg;
            p7_last_reg <= p6_last_reg;
            p7_sum_reg  <= r8 * WEIGHT_R + g8 * WEIGHT_G + b8 * WEIGHT_B;
        end
    end

    // ---------------- divide by 100 through the reciprocal
    logic              p8_vld_reg, p8_req_reg, p8_oor_reg, p8_last_reg;
    logic [PROD_W-1:0] p8_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p8_vld_reg <= 1'b0;
        else if (adv)
            p8_vld_reg <= p7_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p8_req_reg  <= p7_req_reg;
            p8_oor_reg  <= p7_oor_reg;
            p8_last_reg <= p7_last_reg;
            p8_prod_reg <= PROD_W'(p7_sum_reg) * RECIP_100;
        end
    end

    // ---------------- output register
    logic [7:0]  gray;
    logic [23:0] gray_word_reg;
    logic        oor_reg, last_reg;

    assign gray = p8_oor_reg ? 8'd0 : p8_prod_reg[RECIP_SHIFT +: 8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= p8_vld_reg && p8_req_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gray_word_reg <= {gray, gray, gray};
            oor_reg       <= p8_oor_reg;
            last_reg      <= p8_last_reg;
        end
    end

    assign res_valid    = res_valid_reg;
    assign gray_word    = gray_word_reg;
    assign out_of_range = oor_reg;
    assign last_result  = last_reg;

endmodule
